// ===== rtl/lhbp_pkg.sv =====
// Shared types and constants for the local history branch predictor.
`timescale 1ns / 1ps

package lhbp_pkg;

   localparam int DEF_MAX_ENTRIES  = 64;
   localparam int DEF_HISTORY_BITS = 3;
   localparam int DEF_MISS_BITS    = 16;

   localparam int IDX_W  = 10;
   localparam int CFG_W  = 7;
   localparam int CTR_W  = 3;
   localparam int ENT_OW = 6;
   localparam int HIS_OW = 3;
   localparam int MIS_OW = 16;

   localparam logic [CTR_W-1:0] CTR_MAX       = 3'd7;
   localparam logic [CTR_W-1:0] CTR_TAKEN_MIN = 3'd4;
   localparam logic [CFG_W-1:0] CFG_RESET     = 7'd64;

   typedef struct packed {
      logic [IDX_W-1:0] instr_index;
      logic             taken;
   } req_type;

   typedef struct packed {
      logic [ENT_OW-1:0] entry_used;
      logic [HIS_OW-1:0] history_before;
      logic              predicted_taken;
      logic              mispredicted;
      logic [MIS_OW-1:0] entry_misses;
   } rsp_type;

   typedef struct packed {
      logic clearing;
      logic rsp_strobe;
   } back_status_type;

endpackage

// ===== rtl/lhbp_front.sv =====
// Front end: takes requests and reduces the index modulo the entry count, one bit per cycle.
`timescale 1ns / 1ps

module lhbp_front
   import lhbp_pkg::*;
#(
   parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
   localparam int EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start_accept,
   input  req_type              req,
   input  logic [CFG_W-1:0]     entries_n,
   input  logic                 q_full,
   output logic                 push,
   output logic [EW-1:0]        push_entry,
   output logic                 push_taken,
   output logic                 idle
);

   localparam int REM_W  = CFG_W + 1;
   localparam int STEP_W = $clog2(IDX_W);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [IDX_W-1:0] dvd_ff, dvd_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [CFG_W-1:0] n_ff, n_in;
   logic             taken_ff, taken_in;
   logic [REM_W-1:0] trial;

   assign trial = {rem_ff[REM_W-2:0], dvd_ff[IDX_W-1]};

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      n_in     = n_ff;
      taken_in = taken_ff;
      push     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start_accept) begin
               state_in = ST_DIV;
               step_in  = '0;
               dvd_in   = req.instr_index;
               rem_in   = '0;
               n_in     = entries_n;
               taken_in = req.taken;
            end
         end
         ST_DIV: begin
            // restoring step: shift in next dividend bit, subtract if it fits
            rem_in  = (trial >= {1'b0, n_ff}) ? trial - {1'b0, n_ff} : trial;
            dvd_in  = {dvd_ff[IDX_W-2:0], 1'b0};
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(IDX_W - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!q_full) begin
               push     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      step_ff  <= step_in;
      dvd_ff   <= dvd_in;
      rem_ff   <= rem_in;
      n_ff     <= n_in;
      taken_ff <= taken_in;
   end

   assign push_entry = EW'(rem_ff);
   assign push_taken = taken_ff;
   assign idle       = (state_ff == ST_IDLE);

`ifndef SYNTHESIS
   a_rem_below_n: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE |-> rem_ff < {1'b0, n_ff})
      else $error("remainder not reduced below entry count");
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      start_accept && state_ff == ST_IDLE |=> state_ff == ST_DIV)
      else $error("accepted request did not start division");
`endif

endmodule

// ===== rtl/lhbp_queue.sv =====
// Two-entry queue between the front end and the table back end.
`timescale 1ns / 1ps

module lhbp_queue #(
   parameter int W = 7
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [W-1:0] push_data,
   input  logic         pop,
   output logic [W-1:0] pop_data,
   output logic         empty,
   output logic         full
);

   logic [W-1:0] slot_ff [2];
   logic         wptr_ff, wptr_in;
   logic         rptr_ff, rptr_in;
   logic [1:0]   count_ff, count_in;

   always_comb begin
      wptr_in  = push ? ~wptr_ff : wptr_ff;
      rptr_in  = pop ? ~rptr_ff : rptr_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         slot_ff[wptr_ff] <= push_data;
      end
   end

   assign pop_data = slot_ff[rptr_ff];
   assign empty    = (count_ff == 2'd0);
   assign full     = (count_ff == 2'd2);

endmodule

// ===== rtl/lhbp_back.sv =====
// Back end: history, counter and miss tables with read-modify-write and reset clearing.
`timescale 1ns / 1ps

module lhbp_back
   import lhbp_pkg::*;
#(
   parameter int MAX_ENTRIES  = DEF_MAX_ENTRIES,
   parameter int HISTORY_BITS = DEF_HISTORY_BITS,
   parameter int MISS_BITS    = DEF_MISS_BITS,
   localparam int EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            q_empty,
   input  logic [EW:0]     q_data,
   output logic            pop,
   output back_status_type status,
   output rsp_type         rsp
);

   localparam int SLOTS = 1 << HISTORY_BITS;
   localparam int ROW_W = SLOTS * CTR_W;

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_RMW   = 2'd2;

   logic [HISTORY_BITS-1:0] hist_mem [MAX_ENTRIES];
   logic [ROW_W-1:0]        ctr_mem  [MAX_ENTRIES];
   logic [MISS_BITS-1:0]    miss_mem [MAX_ENTRIES];

   logic [1:0]              state_ff, state_in;
   logic [EW-1:0]           clr_ff, clr_in;
   logic [EW-1:0]           entry_ff;
   logic                    taken_ff;
   logic [HISTORY_BITS-1:0] hist_rd_ff;
   logic [ROW_W-1:0]        row_rd_ff;
   logic [MISS_BITS-1:0]    miss_rd_ff;
   rsp_type                 rsp_ff;
   logic                    rsp_valid_ff;

   logic [CTR_W-1:0]        ctr_sel, ctr_new;
   logic [ROW_W-1:0]        row_new;
   logic [HISTORY_BITS-1:0] hist_new;
   logic [MISS_BITS-1:0]    miss_new;
   logic                    pred, miss;
   logic                    we;
   logic [EW-1:0]           waddr;

   always_comb begin
      ctr_sel = '0;
      for (int s = 0; s < SLOTS; s++) begin
         if (HISTORY_BITS'(s) == hist_rd_ff) begin
            ctr_sel = row_rd_ff[s*CTR_W +: CTR_W];
         end
      end
      pred = (ctr_sel >= CTR_TAKEN_MIN);
      miss = (pred != taken_ff);
      if (taken_ff) begin
         ctr_new = (ctr_sel != CTR_MAX) ? ctr_sel + 1'b1 : ctr_sel;
      end else begin
         ctr_new = (ctr_sel != '0) ? ctr_sel - 1'b1 : ctr_sel;
      end
      row_new = row_rd_ff;
      for (int s = 0; s < SLOTS; s++) begin
         if (HISTORY_BITS'(s) == hist_rd_ff) begin
            row_new[s*CTR_W +: CTR_W] = ctr_new;
         end
      end
      hist_new = HISTORY_BITS'({hist_rd_ff, taken_ff});
      miss_new = (miss && miss_rd_ff != '1) ? miss_rd_ff + 1'b1 : miss_rd_ff;
   end

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      pop      = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == EW'(MAX_ENTRIES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!q_empty) begin
               pop      = 1'b1;
               state_in = ST_RMW;
            end
         end
         ST_RMW: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   assign we    = (state_ff == ST_CLEAR) || (state_ff == ST_RMW);
   assign waddr = (state_ff == ST_CLEAR) ? clr_ff : entry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= (state_ff == ST_RMW);
      end
      if (pop) begin
         entry_ff <= q_data[EW:1];
         taken_ff <= q_data[0];
      end
      if (state_ff == ST_RMW) begin
         rsp_ff.entry_used      <= ENT_OW'(entry_ff);
         rsp_ff.history_before  <= HIS_OW'(hist_rd_ff);
         rsp_ff.predicted_taken <= pred;
         rsp_ff.mispredicted    <= miss;
         rsp_ff.entry_misses    <= MIS_OW'(miss_new);
      end
   end

   // table ports: one registered read, one write per cycle
   always_ff @(posedge clock) begin
      if (pop) begin
         hist_rd_ff <= hist_mem[q_data[EW:1]];
         row_rd_ff  <= ctr_mem[q_data[EW:1]];
         miss_rd_ff <= miss_mem[q_data[EW:1]];
      end
      if (we) begin
         hist_mem[waddr] <= (state_ff == ST_CLEAR) ? '0 : hist_new;
         ctr_mem[waddr]  <= (state_ff == ST_CLEAR) ? '0 : row_new;
         miss_mem[waddr] <= (state_ff == ST_CLEAR) ? '0 : miss_new;
      end
   end

   assign status.clearing   = (state_ff == ST_CLEAR);
   assign status.rsp_strobe = rsp_valid_ff;
   assign rsp               = rsp_ff;

`ifndef SYNTHESIS
   a_rmw_strobes: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RMW |=> rsp_valid_ff)
      else $error("update did not produce a response strobe");
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("response strobe held longer than one cycle");
   a_no_pop_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !pop && !rsp_valid_ff)
      else $error("table access during clearing pass");
`endif

endmodule

// ===== rtl/local_history_branch_predictor.sv =====
// Request path to the response strobe: 10 division steps, the queue, then the table RMW.
// A new request is taken only once the bit-serial modulo unit in the front end is idle again.
// Reset: synchronous; afterwards a clearing pass over all MAX_ENTRIES entries zeroes the tables,
// busy stays high meanwhile. Entry count register resets to 64.
// The response strobe lasts one cycle; the receiver cannot stall.
`timescale 1ns / 1ps

module local_history_branch_predictor
   import lhbp_pkg::*;
#(
   parameter int MAX_ENTRIES  = DEF_MAX_ENTRIES,
   parameter int HISTORY_BITS = DEF_HISTORY_BITS,
   parameter int MISS_BITS    = DEF_MISS_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_type          req_data,
   output logic             rsp_strobe,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CFG_W-1:0] csr_data
);

   localparam int EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

   logic [CFG_W-1:0] cfg_ff, cfg_in;
   logic [CFG_W-1:0] entries_n;
   logic             front_idle;
   logic             push, push_taken, pop, q_empty, q_full;
   logic [EW-1:0]    push_entry;
   logic [EW:0]      q_data;
   back_status_type  status;

   assign csr_ready = 1'b1;
   assign cfg_in    = (csr_valid && csr_ready) ? csr_data : cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // zero means one entry; clamp to table depth
   always_comb begin
      if (cfg_ff == '0) begin
         entries_n = CFG_W'(1);
      end else if (32'(cfg_ff) > MAX_ENTRIES) begin
         entries_n = CFG_W'(MAX_ENTRIES);
      end else begin
         entries_n = cfg_ff;
      end
   end

   assign busy = !front_idle || status.clearing;

   lhbp_front #(
      .MAX_ENTRIES(MAX_ENTRIES)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .start_accept (start && !busy),
      .req          (req_data),
      .entries_n    (entries_n),
      .q_full       (q_full),
      .push         (push),
      .push_entry   (push_entry),
      .push_taken   (push_taken),
      .idle         (front_idle)
   );

   lhbp_queue #(
      .W(EW + 1)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_entry, push_taken}),
      .pop       (pop),
      .pop_data  (q_data),
      .empty     (q_empty),
      .full      (q_full)
   );

   lhbp_back #(
      .MAX_ENTRIES  (MAX_ENTRIES),
      .HISTORY_BITS (HISTORY_BITS),
      .MISS_BITS    (MISS_BITS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_data  (q_data),
      .pop     (pop),
      .status  (status),
      .rsp     (rsp_data)
   );

   assign rsp_strobe = status.rsp_strobe;

endmodule
